// File: hw/rtl/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat session supervisor package
// Shared widths, codes and beat formats for the session supervisor.
// ----------------------------------------------------------------------------
package hss_pkg;

    // Width of the stored heartbeat time and of the age arithmetic.
    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int TMO_BITS  = 32;
    localparam int CMP_BITS  = (TIME_BITS > TMO_BITS) ? TIME_BITS : TMO_BITS;

    localparam logic [TMO_BITS-1:0] TIMEOUT_RESET = TMO_BITS'(3000);

    // Command codes.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SYNC      = 3'd1;
    localparam logic [2:0] OP_HEARTBEAT = 3'd2;
    localparam logic [2:0] OP_CHECK     = 3'd3;
    localparam logic [2:0] OP_BEGIN     = 3'd4;

    // Result codes.
    localparam logic [1:0] CODE_OK        = 2'd0;
    localparam logic [1:0] CODE_FAULT     = 2'd1;
    localparam logic [1:0] CODE_NOT_READY = 2'd2;
    localparam logic [1:0] CODE_NO_SESS   = 2'd3;

    // Session states.
    localparam logic [1:0] SES_NONE   = 2'd0;
    localparam logic [1:0] SES_ACTIVE = 2'd1;
    localparam logic [1:0] SES_LOST   = 2'd2;

    // System states.
    localparam logic [2:0] SYS_BOOT    = 3'd0;
    localparam logic [2:0] SYS_IDLE    = 3'd1;
    localparam logic [2:0] SYS_READY   = 3'd2;
    localparam logic [2:0] SYS_RUNNING = 3'd3;
    localparam logic [2:0] SYS_FAULT   = 3'd4;

    typedef struct packed {
        logic [2:0]          op;
        logic [NOW_BITS-1:0] now_ms;
        logic                hardware_ready;
        logic                error_latched;
        logic                safety_error;
        logic                heater_active;
        logic                pump_running;
    } event_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic [2:0] system_state;
        logic [1:0] session_state;
        logic       stop_request;
    } result_t;

    // Priority encode of the system state.
    function automatic logic [2:0] sys_encode(input logic err, input logic act,
                                              input logic init, input logic hw_rdy,
                                              input logic [1:0] sess);
        logic [2:0] s;
        begin
            if (err || (init && !hw_rdy))
            begin
                s = SYS_FAULT;
            end
            else if (!init)
            begin
                s = SYS_BOOT;
            end
            else if (act)
            begin
                s = SYS_RUNNING;
            end
            else if (sess == SES_ACTIVE)
            begin
                s = SYS_READY;
            end
            else
            begin
                s = SYS_IDLE;
            end
            return s;
        end
    endfunction

endpackage

// File: hw/rtl/heartbeat_session_supervisor_unit.sv
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its event beat is accepted.
// Throughput: one event per cycle; the single result register sets this figure,
// and an event is taken whenever that register is empty or being drained.
// Reset: session none, not initialized, hardware not ready, last heartbeat 0,
// timeout 3000 ms, no result pending.
// ----------------------------------------------------------------------------
// Heartbeat session supervisor
// Expires, opens and refreshes a host session from timed command events and
// reports an error code, the system state, the session state and stop requests.
// ----------------------------------------------------------------------------
module heartbeat_session_supervisor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hss_pkg::TMO_BITS-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hss_pkg::event_t               in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hss_pkg::result_t              out_data
);
    import hss_pkg::*;

    logic [TMO_BITS-1:0]  timeout_reg;
    logic                 initialized_reg, initialized_next;
    logic                 hw_ready_reg, hw_ready_next;
    logic [1:0]           session_reg, session_next;
    logic [TIME_BITS-1:0] last_hb_reg, last_hb_next;
    logic                 out_valid_reg;
    result_t              out_data_reg, out_data_next;

    logic                 accept;
    logic                 err, act, expired, is_fault;
    logic [TIME_BITS-1:0] now_t, age;
    logic [1:0]           sess_mid;
    logic [1:0]           code;
    logic                 stop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign err   = in_data.error_latched || in_data.safety_error;
    assign act   = in_data.heater_active || in_data.pump_running;
    assign now_t = TIME_BITS'(in_data.now_ms);
    assign age   = now_t - last_hb_reg;

    // Age is taken modulo the time width and compared unsigned.
    assign expired  = (session_reg == SES_ACTIVE) &&
                      (CMP_BITS'(age) > CMP_BITS'(timeout_reg));
    assign sess_mid = expired ? SES_LOST : session_reg;
    assign is_fault = err || (initialized_reg && !hw_ready_reg);

    always_comb
    begin
        initialized_next = initialized_reg;
        hw_ready_next    = hw_ready_reg;
        session_next     = sess_mid;
        last_hb_next     = last_hb_reg;
        code             = CODE_OK;
        stop             = expired && act;
        if (in_data.op == OP_BEGIN)
        begin
            initialized_next = 1'b1;
            hw_ready_next    = in_data.hardware_ready;
            session_next     = SES_NONE;
            last_hb_next     = '0;
            stop             = 1'b0;
        end
        else if (in_data.op == OP_SYNC)
        begin
            if (is_fault)
            begin
                code = CODE_FAULT;
            end
            else if (!initialized_reg)
            begin
                code = CODE_NOT_READY;
            end
            else
            begin
                session_next = SES_ACTIVE;
                last_hb_next = now_t;
            end
        end
        else if (in_data.op == OP_HEARTBEAT)
        begin
            if (sess_mid != SES_ACTIVE)
            begin
                code = CODE_NO_SESS;
            end
            else
            begin
                last_hb_next = now_t;
            end
        end
        else if (in_data.op == OP_CHECK)
        begin
            if (is_fault)
            begin
                code = CODE_FAULT;
            end
            else if (!initialized_reg)
            begin
                code = CODE_NOT_READY;
            end
            else if (sess_mid != SES_ACTIVE)
            begin
                code = CODE_NO_SESS;
            end
        end
    end

    always_comb
    begin
        out_data_next.result_code   = code;
        out_data_next.system_state  = sys_encode(err, act, initialized_next,
                                                 hw_ready_next, session_next);
        out_data_next.session_state = session_next;
        out_data_next.stop_request  = stop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            initialized_reg <= 1'b0;
            hw_ready_reg    <= 1'b0;
            session_reg     <= SES_NONE;
            last_hb_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (accept)
            begin
                initialized_reg <= initialized_next;
                hw_ready_reg    <= hw_ready_next;
                session_reg     <= session_next;
                last_hb_reg     <= last_hb_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // A sync that expires the session can reopen it in the same beat, so a stop
    // request comes with either a lost or a freshly opened session.
    a_stop_has_session: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stop_request |-> out_data.session_state != SES_NONE)
        else $error("stop request without a session");

    a_begin_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.op == OP_BEGIN |=>
            session_reg == SES_NONE && initialized_reg && last_hb_reg == '0)
        else $error("begin did not reset the session");

    a_begin_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_data.op == OP_BEGIN || in_data.op == OP_TICK) |=>
            out_data.result_code == CODE_OK && out_valid)
        else $error("begin or tick gave a nonzero result code");

    a_err_fault: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_data.error_latched || in_data.safety_error) |=>
            out_data.system_state == SYS_FAULT)
        else $error("error input did not give fault state");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");
`endif

endmodule
